// ===== rtl/qap_pkg.sv =====
// shared types, constants and field layout for the qap cost engine
package qap_pkg;

	localparam int MAX_SIZE_DEF    = 64;
	localparam int ENTRY_WIDTH_DEF = 16;

	// fixed field widths
	localparam int OP_W      = 3;
	localparam int POS_W     = 6;
	localparam int VALUE_W   = 16;
	localparam int COST_W    = 48;
	localparam int SIZE_W    = 7;

	// input tdata layout, lowest bit first
	localparam int ROW_LSB        = 0;
	localparam int COL_LSB        = ROW_LSB + POS_W;
	localparam int VALUE_LSB      = COL_LSB + POS_W;
	localparam int OLD_COST_LSB   = VALUE_LSB + VALUE_W;
	localparam int FIRST_POS_LSB  = OLD_COST_LSB + COST_W;
	localparam int SECOND_POS_LSB = FIRST_POS_LSB + POS_W;
	localparam int IN_TDATA_W     = ((SECOND_POS_LSB + POS_W + 7) / 8) * 8;
	localparam int OUT_TDATA_W    = ((COST_W + 7) / 8) * 8;

	// configuration port
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = SIZE_W;
	localparam logic [CFG_IDX_W-1:0] REG_SYMMETRIC_MODE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SIZE_IN_USE    = 1'd1;
	localparam logic [SIZE_W-1:0]    SIZE_RESET         = 7'd64;

	// drain state length, so the accumulator holds the final sum once done is reached
	localparam int DRAIN_CYCLES = 4;
	localparam int DRAIN_W      = $clog2(DRAIN_CYCLES);

	typedef enum logic [OP_W-1:0] {
		OP_LOAD_FLOW = 3'd0,
		OP_LOAD_DIST = 3'd1,
		OP_LOAD_PERM = 3'd2,
		OP_FULL_COST = 3'd3,
		OP_SWAP_COST = 3'd4
	} qap_op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_PRE,
		ST_RUN,
		ST_DRAIN,
		ST_DONE
	} qap_state_t;

	// request handed from the port to the sequencer
	typedef struct packed {
		logic              valid;
		qap_op_t           op;
		logic [POS_W-1:0]  first_pos;
		logic [POS_W-1:0]  second_pos;
	} qap_req_t;

	// term token traveling down the datapath
	typedef struct packed {
		logic valid;
		logic swap;
	} qap_tok_t;

	// accumulator start
	typedef struct packed {
		logic              load;
		logic              dbl;
		logic [COST_W-1:0] init;
	} qap_start_t;

endpackage

// ===== rtl/qap_ram.sv =====
// generic ram, one write port and two registered read ports
module qap_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	output logic [WIDTH-1:0]         rdata_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// ===== rtl/qap_seq.sv =====
// sequencer: walks pairs or positions and issues store reads
module qap_seq #(
	parameter int MAX_SIZE = qap_pkg::MAX_SIZE_DEF,
	parameter int IDX_W    = $clog2(MAX_SIZE),
	parameter int CNT_W    = $clog2(MAX_SIZE + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  qap_pkg::qap_req_t     req,
	input  logic [CNT_W-1:0]      n,
	input  logic                  sym,
	input  logic                  out_free,
	input  logic [IDX_W-1:0]      perm_rdata_a,
	input  logic [IDX_W-1:0]      perm_rdata_b,
	output logic                  idle,
	output logic                  done,
	output logic [IDX_W-1:0]      perm_raddr_a,
	output logic [IDX_W-1:0]      perm_raddr_b,
	output logic [2*IDX_W-1:0]    flow_raddr_a,
	output logic [2*IDX_W-1:0]    flow_raddr_b,
	output logic [2*IDX_W-1:0]    dist_raddr_a,
	output logic [2*IDX_W-1:0]    dist_raddr_b,
	output qap_pkg::qap_tok_t     tok_s1
);

	qap_pkg::qap_state_t state_q, state_d;
	logic [IDX_W-1:0]             i_q, i_d, j_q, j_d;
	logic                         half_q, half_d;
	logic                         swap_q, swap_d;
	logic [qap_pkg::POS_W-1:0]    a_q, a_d, b_q, b_d;
	logic [qap_pkg::DRAIN_W-1:0]  drain_q, drain_d;
	qap_pkg::qap_tok_t            tok_s0;
	logic                         half_s1;
	logic                         pre_s1;
	logic [IDX_W-1:0]             pa_q, pb_q;
	logic [IDX_W-1:0]             a_idx, b_idx;
	logic                         i_last, j_last;
	logic                         pos_bad;

	assign a_idx  = a_q[IDX_W-1:0];
	assign b_idx  = b_q[IDX_W-1:0];
	assign i_last = CNT_W'(i_q) == n - CNT_W'(1);
	assign j_last = CNT_W'(j_q) == n - CNT_W'(1);
	assign idle   = state_q == qap_pkg::ST_IDLE;

	assign pos_bad = (qap_pkg::SIZE_W'(req.first_pos) >= qap_pkg::SIZE_W'(n))
		|| (qap_pkg::SIZE_W'(req.second_pos) >= qap_pkg::SIZE_W'(n));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= qap_pkg::ST_IDLE;
			i_q     <= '0;
			j_q     <= '0;
			half_q  <= 1'b0;
			swap_q  <= 1'b0;
			a_q     <= '0;
			b_q     <= '0;
			drain_q <= '0;
			tok_s1  <= '0;
			half_s1 <= 1'b0;
			pre_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			i_q     <= i_d;
			j_q     <= j_d;
			half_q  <= half_d;
			swap_q  <= swap_d;
			a_q     <= a_d;
			b_q     <= b_d;
			drain_q <= drain_d;
			tok_s1  <= tok_s0;
			half_s1 <= half_q;
			pre_s1  <= state_q == qap_pkg::ST_PRE;
		end
	end

	// swapped positions' locations, read once before the walk
	always_ff @(posedge clk) begin
		if (pre_s1) begin
			pa_q <= perm_rdata_a;
			pb_q <= perm_rdata_b;
		end
	end

	always_comb begin
		state_d = state_q;
		i_d     = i_q;
		j_d     = j_q;
		half_d  = half_q;
		swap_d  = swap_q;
		a_d     = a_q;
		b_d     = b_q;
		drain_d = drain_q;
		tok_s0  = '0;
		done    = 1'b0;
		unique case (state_q)
			qap_pkg::ST_IDLE: begin
				if (req.valid) begin
					i_d     = '0;
					j_d     = '0;
					half_d  = 1'b0;
					drain_d = '0;
					a_d     = req.first_pos;
					b_d     = req.second_pos;
					priority case (req.op)
						qap_pkg::OP_FULL_COST: begin
							swap_d  = 1'b0;
							state_d = (n == '0) ? qap_pkg::ST_DRAIN : qap_pkg::ST_RUN;
						end
						qap_pkg::OP_SWAP_COST: begin
							swap_d  = 1'b1;
							state_d = (n == '0 || pos_bad) ? qap_pkg::ST_DRAIN
								: qap_pkg::ST_PRE;
						end
						default: begin
						end
					endcase
				end
			end
			qap_pkg::ST_PRE: begin
				state_d = qap_pkg::ST_RUN;
			end
			qap_pkg::ST_RUN: begin
				if (!swap_q) begin
					// skip the diagonal, and the lower triangle when symmetric
					tok_s0.valid = (i_q != j_q) && !(sym && (j_q < i_q));
					tok_s0.swap  = 1'b0;
					if (j_last) begin
						j_d = '0;
						if (i_last) begin
							state_d = qap_pkg::ST_DRAIN;
						end else begin
							i_d = i_q + IDX_W'(1);
						end
					end else begin
						j_d = j_q + IDX_W'(1);
					end
				end else begin
					tok_s0.valid = (i_q != a_idx) && (i_q != b_idx);
					tok_s0.swap  = 1'b1;
					half_d       = !half_q;
					if (half_q) begin
						if (i_last) begin
							state_d = qap_pkg::ST_DRAIN;
						end else begin
							i_d = i_q + IDX_W'(1);
						end
					end
				end
			end
			qap_pkg::ST_DRAIN: begin
				if (drain_q == qap_pkg::DRAIN_W'(qap_pkg::DRAIN_CYCLES - 1)) begin
					state_d = qap_pkg::ST_DONE;
				end else begin
					drain_d = drain_q + qap_pkg::DRAIN_W'(1);
				end
			end
			qap_pkg::ST_DONE: begin
				if (out_free) begin
					done    = 1'b1;
					state_d = qap_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = qap_pkg::ST_IDLE;
			end
		endcase
	end

	// issue stage
	assign perm_raddr_a = (state_q == qap_pkg::ST_PRE) ? a_idx : i_q;
	assign perm_raddr_b = (state_q == qap_pkg::ST_PRE) ? b_idx : j_q;

	always_comb begin
		if (!swap_q) begin
			flow_raddr_a = {i_q, j_q};
			flow_raddr_b = {i_q, j_q};
		end else if (half_q) begin
			flow_raddr_a = {i_q, a_idx};
			flow_raddr_b = {i_q, b_idx};
		end else begin
			flow_raddr_a = {a_idx, i_q};
			flow_raddr_b = {b_idx, i_q};
		end
	end

	// second stage: distance addresses from the permuted locations
	always_comb begin
		if (!tok_s1.swap) begin
			dist_raddr_a = {perm_rdata_a, perm_rdata_b};
			dist_raddr_b = {perm_rdata_a, perm_rdata_b};
		end else if (half_s1) begin
			dist_raddr_a = {perm_rdata_a, pb_q};
			dist_raddr_b = {perm_rdata_a, pa_q};
		end else begin
			dist_raddr_a = {pb_q, perm_rdata_a};
			dist_raddr_b = {pa_q, perm_rdata_a};
		end
	end

endmodule

// ===== rtl/qap_datapath.sv =====
// difference, multiply and accumulate stages
module qap_datapath #(
	parameter int ENTRY_WIDTH = qap_pkg::ENTRY_WIDTH_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  qap_pkg::qap_start_t        start,
	input  qap_pkg::qap_tok_t          tok_s1,
	input  logic [ENTRY_WIDTH-1:0]     flow_rdata_a,
	input  logic [ENTRY_WIDTH-1:0]     flow_rdata_b,
	input  logic [ENTRY_WIDTH-1:0]     dist_rdata_a,
	input  logic [ENTRY_WIDTH-1:0]     dist_rdata_b,
	output logic [qap_pkg::COST_W-1:0] result
);

	localparam int DIFF_W = ENTRY_WIDTH + 1;
	localparam int PROD_W = 2 * DIFF_W;

	qap_pkg::qap_tok_t           tok_s2;
	logic [ENTRY_WIDTH-1:0]      fa_s2, fb_s2;
	logic                        vld_s3, vld_s4;
	logic signed [DIFF_W-1:0]    fdiff, ddiff;
	logic signed [DIFF_W-1:0]    fdiff_s3, ddiff_s3;
	logic signed [PROD_W-1:0]    prod_s4;
	logic [qap_pkg::COST_W-1:0]  acc_q;
	logic                        dbl_q;
	logic [ENTRY_WIDTH-1:0]      fb_g, db_g;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tok_s2 <= '0;
			vld_s3 <= 1'b0;
			vld_s4 <= 1'b0;
			dbl_q  <= 1'b0;
		end else begin
			tok_s2 <= tok_s1;
			vld_s3 <= tok_s2.valid;
			vld_s4 <= vld_s3;
			if (start.load) begin
				dbl_q <= start.dbl;
			end
		end
	end

	// full cost uses only the a ports
	assign fb_g  = tok_s2.swap ? fb_s2 : '0;
	assign db_g  = tok_s2.swap ? dist_rdata_b : '0;
	assign fdiff = $signed({1'b0, fa_s2}) - $signed({1'b0, fb_g});
	assign ddiff = $signed({1'b0, dist_rdata_a}) - $signed({1'b0, db_g});

	always_ff @(posedge clk) begin
		fa_s2    <= flow_rdata_a;
		fb_s2    <= flow_rdata_b;
		fdiff_s3 <= fdiff;
		ddiff_s3 <= ddiff;
		prod_s4  <= fdiff_s3 * ddiff_s3;
		if (start.load) begin
			acc_q <= start.init;
		end else if (vld_s4) begin
			acc_q <= acc_q + {{(qap_pkg::COST_W - PROD_W){prod_s4[PROD_W-1]}}, prod_s4};
		end
	end

	// symmetric full cost counts each pair once, so double it
	assign result = dbl_q ? {acc_q[qap_pkg::COST_W-2:0], 1'b0} : acc_q;

endmodule

// ===== rtl/qap_cost_and_swap_delta.sv =====
// top level of the quadratic assignment cost and swap delta engine
//
//  channel   direction  handshake                    payload
//  s_axis    in         s_axis_tvalid/s_axis_tready  tdata: row, col, value, old_cost,
//                                                    first_pos, second_pos; tuser: op
//  m_axis    out        m_axis_tvalid/m_axis_tready  tdata: cost
//  cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// loads are single store writes, taken one per cycle while idle; n is the size in use, capped at MAX_SIZE
// full cost: one matrix pair per cycle, read through the a ports of the flow and
//   distance rams
// swap cost: each position walks two halves (four flow and four distance reads
//   over two read ports per ram)
// reset clears control and configuration only; stores hold garbage until loaded
// a finished result waits in the output register; a following request runs but
//   holds its result until that register is free
module qap_cost_and_swap_delta #(
	parameter int MAX_SIZE    = qap_pkg::MAX_SIZE_DEF,
	parameter int ENTRY_WIDTH = qap_pkg::ENTRY_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            s_axis_tvalid,
	output logic                            s_axis_tready,
	// row, col, value, old_cost, first_pos, second_pos
	input  logic [qap_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
	// op
	input  logic [qap_pkg::OP_W-1:0]        s_axis_tuser,
	output logic                            m_axis_tvalid,
	input  logic                            m_axis_tready,
	// cost
	output logic [qap_pkg::OUT_TDATA_W-1:0] m_axis_tdata,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [qap_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [qap_pkg::CFG_DATA_W-1:0]  cfg_data
);

	localparam int IDX_W = $clog2(MAX_SIZE);
	localparam int CNT_W = $clog2(MAX_SIZE + 1);
	localparam int MAT_DEPTH = 1 << (2 * IDX_W);

	// unpacked input fields
	logic                            accept;
	qap_pkg::qap_op_t                op;
	logic [qap_pkg::POS_W-1:0]       row, col, first_pos, second_pos;
	logic [qap_pkg::VALUE_W-1:0]     value;
	logic [qap_pkg::COST_W-1:0]      old_cost;

	// configuration
	logic                            sym_q;
	logic [qap_pkg::SIZE_W-1:0]      size_q;
	logic [CNT_W-1:0]                n;

	// store writes
	logic                            rc_ok;
	logic                            flow_we, dist_we, perm_we;
	logic [2*IDX_W-1:0]              mat_waddr;

	// store reads
	logic [IDX_W-1:0]                perm_raddr_a, perm_raddr_b;
	logic [IDX_W-1:0]                perm_rdata_a, perm_rdata_b;
	logic [2*IDX_W-1:0]              flow_raddr_a, flow_raddr_b;
	logic [2*IDX_W-1:0]              dist_raddr_a, dist_raddr_b;
	logic [ENTRY_WIDTH-1:0]          flow_rdata_a, flow_rdata_b;
	logic [ENTRY_WIDTH-1:0]          dist_rdata_a, dist_rdata_b;

	// control
	qap_pkg::qap_req_t               req;
	qap_pkg::qap_start_t             start;
	qap_pkg::qap_tok_t               tok_s1;
	logic                            idle, done, out_free;
	logic [qap_pkg::COST_W-1:0]      result;

	// output register
	logic                            out_valid_q;
	logic [qap_pkg::COST_W-1:0]      cost_q;

	assign accept     = s_axis_tvalid && s_axis_tready;
	assign op         = qap_pkg::qap_op_t'(s_axis_tuser);
	assign row        = s_axis_tdata[qap_pkg::ROW_LSB +: qap_pkg::POS_W];
	assign col        = s_axis_tdata[qap_pkg::COL_LSB +: qap_pkg::POS_W];
	assign value      = s_axis_tdata[qap_pkg::VALUE_LSB +: qap_pkg::VALUE_W];
	assign old_cost   = s_axis_tdata[qap_pkg::OLD_COST_LSB +: qap_pkg::COST_W];
	assign first_pos  = s_axis_tdata[qap_pkg::FIRST_POS_LSB +: qap_pkg::POS_W];
	assign second_pos = s_axis_tdata[qap_pkg::SECOND_POS_LSB +: qap_pkg::POS_W];

	// requests are taken only between walks; loads are single store writes
	assign s_axis_tready = idle;

	// config is only to be written while idle; the block itself does not enforce it, so it is always taken
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sym_q  <= 1'b0;
			size_q <= qap_pkg::SIZE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				qap_pkg::REG_SYMMETRIC_MODE: sym_q  <= cfg_data[0];
				qap_pkg::REG_SIZE_IN_USE:    size_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// sizes above the store capacity act as the capacity
	assign n = (size_q > qap_pkg::SIZE_W'(MAX_SIZE)) ? CNT_W'(MAX_SIZE) : CNT_W'(size_q);

	// out-of-range loads are dropped
	assign rc_ok = (qap_pkg::SIZE_W'(row) < qap_pkg::SIZE_W'(MAX_SIZE))
		&& (qap_pkg::SIZE_W'(col) < qap_pkg::SIZE_W'(MAX_SIZE));
	assign flow_we = accept && (op == qap_pkg::OP_LOAD_FLOW) && rc_ok;
	assign dist_we = accept && (op == qap_pkg::OP_LOAD_DIST) && rc_ok;
	assign perm_we = accept && (op == qap_pkg::OP_LOAD_PERM)
		&& (qap_pkg::SIZE_W'(row) < qap_pkg::SIZE_W'(MAX_SIZE))
		&& (value < qap_pkg::VALUE_W'(MAX_SIZE));
	assign mat_waddr = {row[IDX_W-1:0], col[IDX_W-1:0]};

	qap_ram #(
		.WIDTH (ENTRY_WIDTH),
		.DEPTH (MAT_DEPTH)
	) u_flow_ram (
		.clk     (clk),
		.we      (flow_we),
		.waddr   (mat_waddr),
		.wdata   (value[ENTRY_WIDTH-1:0]),
		.raddr_a (flow_raddr_a),
		.rdata_a (flow_rdata_a),
		.raddr_b (flow_raddr_b),
		.rdata_b (flow_rdata_b)
	);

	qap_ram #(
		.WIDTH (ENTRY_WIDTH),
		.DEPTH (MAT_DEPTH)
	) u_dist_ram (
		.clk     (clk),
		.we      (dist_we),
		.waddr   (mat_waddr),
		.wdata   (value[ENTRY_WIDTH-1:0]),
		.raddr_a (dist_raddr_a),
		.rdata_a (dist_rdata_a),
		.raddr_b (dist_raddr_b),
		.rdata_b (dist_rdata_b)
	);

	qap_ram #(
		.WIDTH (IDX_W),
		.DEPTH (MAX_SIZE)
	) u_perm_ram (
		.clk     (clk),
		.we      (perm_we),
		.waddr   (row[IDX_W-1:0]),
		.wdata   (value[IDX_W-1:0]),
		.raddr_a (perm_raddr_a),
		.rdata_a (perm_rdata_a),
		.raddr_b (perm_raddr_b),
		.rdata_b (perm_rdata_b)
	);

	// sequencer request and accumulator start on acceptance
	assign req.valid      = accept;
	assign req.op         = op;
	assign req.first_pos  = first_pos;
	assign req.second_pos = second_pos;

	assign start.load = accept
		&& (op == qap_pkg::OP_FULL_COST || op == qap_pkg::OP_SWAP_COST);
	assign start.dbl  = (op == qap_pkg::OP_FULL_COST) && sym_q;
	assign start.init = (op == qap_pkg::OP_SWAP_COST) ? old_cost : '0;

	qap_seq #(
		.MAX_SIZE (MAX_SIZE),
		.IDX_W    (IDX_W),
		.CNT_W    (CNT_W)
	) u_seq (
		.clk          (clk),
		.arst_n       (arst_n),
		.req          (req),
		.n            (n),
		.sym          (sym_q),
		.out_free     (out_free),
		.perm_rdata_a (perm_rdata_a),
		.perm_rdata_b (perm_rdata_b),
		.idle         (idle),
		.done         (done),
		.perm_raddr_a (perm_raddr_a),
		.perm_raddr_b (perm_raddr_b),
		.flow_raddr_a (flow_raddr_a),
		.flow_raddr_b (flow_raddr_b),
		.dist_raddr_a (dist_raddr_a),
		.dist_raddr_b (dist_raddr_b),
		.tok_s1       (tok_s1)
	);

	qap_datapath #(
		.ENTRY_WIDTH (ENTRY_WIDTH)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.tok_s1       (tok_s1),
		.flow_rdata_a (flow_rdata_a),
		.flow_rdata_b (flow_rdata_b),
		.dist_rdata_a (dist_rdata_a),
		.dist_rdata_b (dist_rdata_b),
		.result       (result)
	);

	// output register, refilled in the same cycle it drains
	assign out_free = !out_valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (done) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			cost_q <= result;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = qap_pkg::OUT_TDATA_W'(cost_q);

endmodule
